// File: sv/freshness_table_update_top_assert.svh
// Assertion macros for the freshness table block
`ifndef FRESHNESS_TABLE_UPDATE_TOP_ASSERT_SVH
`define FRESHNESS_TABLE_UPDATE_TOP_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define FTU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check that the consequent holds in the cycle after the antecedent
`define FTU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/ftu_pkg.sv
package ftu_pkg;

  localparam int unsigned IdW     = 8;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned DistW   = 8;
  localparam int unsigned SeenW   = 16;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    VERDICT_FRESH   = 2'd0,
    VERDICT_CURRENT = 2'd1,
    VERDICT_STALE   = 2'd2,
    VERDICT_SKIP    = 2'd3
  } verdict_e;

  typedef struct packed {
    logic [IdW-1:0]   node_id;
    logic [TimeW-1:0] item_time;
    logic [DistW-1:0] hop_distance;
    logic [TimeW-1:0] now_ms;
    logic             from_sender;
  } in_item_t;

  typedef struct packed {
    verdict_e         verdict;
    logic [DistW-1:0] stored_distance;
    logic [SeenW-1:0] seen_count;
    logic             new_neighbor;
  } out_item_t;

  typedef struct packed {
    logic             skip;
    logic [IdW-1:0]   node_id;
    logic [TimeW-1:0] item_time;
    logic [DistW-1:0] dist1;
    logic             from_sender;
  } work_t;

  typedef struct packed {
    logic  push;
    work_t data;
  } push_t;

  typedef struct packed {
    logic  empty;
    work_t head;
  } head_t;

endpackage

// File: sv/ftu_stream_if.sv
interface ftu_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: sv/freshness_table_update_top.sv
// Gossip freshness table: each request merges one gossip item into a per-node
// table (newest timestamp, distance, seen count) and a known-neighbor map, and
// returns one result. A front stage classifies requests (out-of-range ids and
// own-node ids not from the sender are skipped) into a two-entry queue; the
// back stage does a read-modify-write of the single-port table (read when idle,
// merge and write-back in the calc state, held while the last result waits),
// taking no new request until done. Valid and neighbor bits clear at reset with
// no clearing pass. Write own_node_id only while no request is in flight.
module freshness_table_update_top #(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [ftu_pkg::IdW-1:0] cfg_wdata_i,
  ftu_stream_if.sink              item_i,
  ftu_stream_if.source            result_o
);
  import ftu_pkg::*;

  push_t push;
  head_t head;
  logic  q_full;
  logic  pop;

  ftu_front #(.NODE_COUNT(NODE_COUNT)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .q_full_i    (q_full),
    .push_o      (push)
  );

  ftu_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .full_o (q_full),
    .head_o (head)
  );

  ftu_back #(.NODE_COUNT(NODE_COUNT)) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .result_o (result_o)
  );

`include "freshness_table_update_top_assert.svh"

  `FTU_ASSERT_SAME(a_no_push_when_full, q_full, !push.push, "push into full queue")
  `FTU_ASSERT_SAME(a_pop_not_empty, pop, !head.empty, "pop from empty queue")
  `FTU_ASSERT_SAME(a_skip_zero, result_o.valid && (result_o.payload.verdict == VERDICT_SKIP),
    (result_o.payload.stored_distance == '0) && (result_o.payload.seen_count == '0) &&
    !result_o.payload.new_neighbor, "skipped result carries nonzero fields")
  `FTU_ASSERT_SAME(a_fresh_seen_one,
    result_o.valid && (result_o.payload.verdict == VERDICT_FRESH),
    result_o.payload.seen_count == 16'd1, "fresh result seen count not one")
  `FTU_ASSERT_NEXT(a_pop_then_no_pop, pop, !pop, "back stage popped on consecutive cycles")

endmodule

// File: sv/ftu_front.sv
module ftu_front #(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [ftu_pkg::IdW-1:0]   cfg_wdata_i,
  ftu_stream_if.sink                item_i,
  input  logic                      q_full_i,
  output ftu_pkg::push_t            push_o
);
  import ftu_pkg::*;

  logic [IdW-1:0]   own_id_q;
  logic [DistW-1:0] dist1;
  logic             out_of_range;
  logic             own_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q <= '0;
    end else if (cfg_we_i) begin
      own_id_q <= cfg_wdata_i;
    end
  end

  assign dist1 = (item_i.payload.hop_distance == {DistW{1'b1}}) ?
                 {DistW{1'b1}} : item_i.payload.hop_distance + DistW'(1);

  assign out_of_range = (32'(item_i.payload.node_id) >= 32'(NODE_COUNT));
  assign own_item     = !item_i.payload.from_sender && (item_i.payload.node_id == own_id_q);

  assign item_i.ready = !q_full_i;

  always_comb begin
    push_o.push             = item_i.valid && !q_full_i;
    push_o.data.skip        = out_of_range || own_item;
    push_o.data.node_id     = item_i.payload.node_id;
    push_o.data.item_time   = item_i.payload.item_time;
    push_o.data.dist1       = dist1;
    push_o.data.from_sender = item_i.payload.from_sender;
  end

endmodule

// File: sv/ftu_queue.sv
module ftu_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ftu_pkg::push_t push_i,
  input  logic           pop_i,
  output logic           full_o,
  output ftu_pkg::head_t head_o
);
  import ftu_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

  work_t           slots_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            do_push, do_pop;

  assign full_o       = (count_q == (PtrW+1)'(QueueDepth));
  assign head_o.empty = (count_q == '0);
  assign head_o.head  = slots_q[rd_ptr_q];

  assign do_push = push_i.push && !full_o;
  assign do_pop  = pop_i && !head_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + (PtrW+1)'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - (PtrW+1)'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_i.data;
    end
  end

endmodule

// File: sv/ftu_back.sv
module ftu_back #(
  parameter int unsigned NODE_COUNT = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  ftu_pkg::head_t head_i,
  output logic           pop_o,
  ftu_stream_if.source   result_o
);
  import ftu_pkg::*;

  localparam int unsigned Depth = (NODE_COUNT < 256) ? NODE_COUNT : 256;
  localparam int unsigned IdxW  = $clog2(Depth);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_CALC = 1'b1;

  typedef struct packed {
    logic [TimeW-1:0] item_time;
    logic [DistW-1:0] distance;
    logic [SeenW-1:0] seen;
  } entry_t;

  entry_t          table_mem [Depth];
  entry_t          rd_data_q;
  entry_t          wr_data;
  logic            wr_en;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] idx;

  logic            state_q, state_d;
  work_t           work_q;
  logic            load_work;

  logic [Depth-1:0] valid_q;
  logic [Depth-1:0] known_q;
  logic             set_bits;
  logic             learned;

  out_item_t       res_q, res_d;
  logic            res_valid_q, res_valid_d;
  logic            out_free;
  logic            finish;

  assign rd_idx   = head_i.head.node_id[IdxW-1:0];
  assign idx      = work_q.node_id[IdxW-1:0];
  assign out_free = !res_valid_q || result_o.ready;

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    load_work = 1'b0;
    finish    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!head_i.empty) begin
          pop_o     = 1'b1;
          load_work = 1'b1;
          state_d   = ST_CALC;
        end
      end
      ST_CALC: begin
        if (out_free) begin
          finish  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    learned  = 1'b0;
    wr_en    = 1'b0;
    set_bits = 1'b0;
    wr_data  = rd_data_q;
    res_d    = '{verdict: VERDICT_SKIP, stored_distance: '0, seen_count: '0,
                 new_neighbor: 1'b0};
    if (!work_q.skip) begin
      set_bits = finish;
      learned  = work_q.from_sender && !known_q[idx];
      if (!valid_q[idx] || (work_q.item_time > rd_data_q.item_time)) begin
        wr_data.item_time = work_q.item_time;
        wr_data.distance  = work_q.dist1;
        wr_data.seen      = SeenW'(1);
        wr_en             = finish;
        res_d.verdict     = VERDICT_FRESH;
      end else if (work_q.item_time < rd_data_q.item_time) begin
        res_d.verdict     = VERDICT_STALE;
      end else begin
        if (rd_data_q.distance > work_q.dist1) begin
          wr_data.distance = work_q.dist1;
        end
        if (rd_data_q.seen != {SeenW{1'b1}}) begin
          wr_data.seen = rd_data_q.seen + SeenW'(1);
        end
        wr_en         = finish;
        res_d.verdict = VERDICT_CURRENT;
      end
      res_d.stored_distance = wr_data.distance;
      res_d.seen_count      = wr_data.seen;
      res_d.new_neighbor    = learned;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (result_o.ready) begin
      res_valid_d = 1'b0;
    end
    if (finish) begin
      res_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
      valid_q     <= '0;
      known_q     <= '0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (set_bits) begin
        valid_q[idx] <= 1'b1;
        if (work_q.from_sender) begin
          known_q[idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_work) begin
      work_q <= head_i.head;
    end
    if (finish) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      table_mem[idx] <= wr_data;
    end
    if (load_work) begin
      rd_data_q <= table_mem[rd_idx];
    end
  end

  assign result_o.valid   = res_valid_q;
  assign result_o.payload = res_q;

endmodule
